// ----- rtl/ppd_pkg.sv -----
`timescale 1ns / 1ps

package ppd_pkg;

    localparam int COORD_W_DEF = 32;
    localparam int DIST_W      = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_ACC,
        ST_SQ_T,
        ST_SQ_C,
        ST_FIN
    } t_state;

    typedef enum logic [3:0] {
        OP_N0A,
        OP_N0B,
        OP_N1A,
        OP_N1B,
        OP_N2A,
        OP_N2B,
        OP_D0,
        OP_D1,
        OP_D2,
        OP_Q0,
        OP_Q1,
        OP_Q2,
        OP_DD
    } t_op;

    typedef struct packed {
        logic in_stall;
        logic load_out;
    } t_ctrl;

endpackage

// ----- rtl/point_plane_distance_range_core.sv -----
`timescale 1ns / 1ps

// Channel | valid      | stall       | payload
// --------+------------+-------------+------------------------------------------
// in      | i_in_valid | o_in_stall  | i_{p,a,b,c}_{x,y,z}
// out     | o_out_valid| i_out_stall | o_distance o_range_min o_range_max
//         |            |             | o_degenerate
//
// One transaction at a time. A shared shift-add multiplier takes one
// multiplier bit per cycle over 13 products, then the root search finds
// one result bit per pass through ST_SQ_T and ST_SQ_C.
// Reset is synchronous, active low; the range restarts at all ones / zero.
// A finished result waits in the output register while a new transaction runs.
module point_plane_distance_range_core
    import ppd_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_W_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [COORD_WIDTH-1:0] i_p_x,
    input  logic [COORD_WIDTH-1:0] i_p_y,
    input  logic [COORD_WIDTH-1:0] i_p_z,
    input  logic [COORD_WIDTH-1:0] i_a_x,
    input  logic [COORD_WIDTH-1:0] i_a_y,
    input  logic [COORD_WIDTH-1:0] i_a_z,
    input  logic [COORD_WIDTH-1:0] i_b_x,
    input  logic [COORD_WIDTH-1:0] i_b_y,
    input  logic [COORD_WIDTH-1:0] i_b_z,
    input  logic [COORD_WIDTH-1:0] i_c_x,
    input  logic [COORD_WIDTH-1:0] i_c_y,
    input  logic [COORD_WIDTH-1:0] i_c_z,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [DIST_W-1:0]      o_distance,
    output logic [DIST_W-1:0]      o_range_min,
    output logic [DIST_W-1:0]      o_range_max,
    output logic                   o_degenerate
);

    localparam int W   = COORD_WIDTH;
    localparam int DW  = W + 1;
    localparam int NW  = 2 * W + 3;
    localparam int TW  = 3 * W + 6;
    localparam int NNW = 4 * W + 8;
    localparam int PW  = 6 * W + 12;
    localparam int AW  = PW + 1;
    localparam int SW  = ((PW > 4 * W + 74) ? PW : 4 * W + 74) + 1;
    localparam int CW  = $clog2(TW + 1);
    localparam int QSH = 2 * (DIST_W - 1);
    localparam int KW  = $clog2(DIST_W);

    t_state r_state, n_state;
    t_ctrl  s_ctrl;
    t_op    r_op;

    logic signed [DW-1:0] r_ab [3];
    logic signed [DW-1:0] r_ac [3];
    logic signed [DW-1:0] r_pa [3];
    logic signed [NW-1:0] r_n  [3];
    logic [TW-1:0]        r_dot;
    logic [NNW-1:0]       r_nn;
    logic signed [AW-1:0] r_acc;
    logic [PW-1:0]        r_mcand;
    logic [TW-1:0]        r_mplier;
    logic [PW-1:0]        r_prod;
    logic                 r_pneg;
    logic [CW-1:0]        r_len;
    logic [CW-1:0]        r_cnt;
    logic [SW-1:0]        r_r, r_a, r_b, r_t;
    logic [DIST_W-1:0]    r_q;
    logic [KW-1:0]        r_k;
    logic                 r_ovalid;
    logic [DIST_W-1:0]    r_dist, r_min, r_max;
    logic                 r_odeg;

    logic signed [DW-1:0] s_pin [3];
    logic signed [DW-1:0] s_ain [3];
    logic signed [DW-1:0] s_bin [3];
    logic signed [DW-1:0] s_cin [3];
    logic signed [TW-1:0] e_ab [3];
    logic signed [TW-1:0] e_ac [3];
    logic signed [TW-1:0] e_pa [3];
    logic signed [TW-1:0] e_n  [3];
    logic signed [TW-1:0] e_dot;

    logic signed [TW-1:0] s_mx, s_my;
    logic                 s_neg, s_first;
    logic [CW-1:0]        s_len;
    logic [TW-1:0]        s_magx, s_magy;
    logic signed [AW-1:0] s_padd, s_accn, s_accneg;
    logic                 s_deg;
    logic [SW-1:0]        s_rdiff;
    logic                 s_fit;
    logic [DIST_W-1:0]    s_dist;

    assign s_pin[0] = {i_p_x[W-1], i_p_x};
    assign s_pin[1] = {i_p_y[W-1], i_p_y};
    assign s_pin[2] = {i_p_z[W-1], i_p_z};
    assign s_ain[0] = {i_a_x[W-1], i_a_x};
    assign s_ain[1] = {i_a_y[W-1], i_a_y};
    assign s_ain[2] = {i_a_z[W-1], i_a_z};
    assign s_bin[0] = {i_b_x[W-1], i_b_x};
    assign s_bin[1] = {i_b_y[W-1], i_b_y};
    assign s_bin[2] = {i_b_z[W-1], i_b_z};
    assign s_cin[0] = {i_c_x[W-1], i_c_x};
    assign s_cin[1] = {i_c_y[W-1], i_c_y};
    assign s_cin[2] = {i_c_z[W-1], i_c_z};

    for (genvar g = 0; g < 3; g++) begin : g_ext
        assign e_ab[g] = {{(TW - DW){r_ab[g][DW-1]}}, r_ab[g]};
        assign e_ac[g] = {{(TW - DW){r_ac[g][DW-1]}}, r_ac[g]};
        assign e_pa[g] = {{(TW - DW){r_pa[g][DW-1]}}, r_pa[g]};
        assign e_n[g]  = {{(TW - NW){r_n[g][NW-1]}}, r_n[g]};
    end
    assign e_dot = r_dot;

    // operand selection for the shared multiplier
    always_comb begin
        s_mx    = e_ab[1];
        s_my    = e_ac[2];
        s_neg   = 1'b0;
        s_first = 1'b0;
        s_len   = CW'(DW);
        unique case (r_op)
            OP_N0A: begin s_mx = e_ab[1]; s_my = e_ac[2]; s_first = 1'b1; end
            OP_N0B: begin s_mx = e_ab[2]; s_my = e_ac[1]; s_neg = 1'b1; end
            OP_N1A: begin s_mx = e_ab[2]; s_my = e_ac[0]; s_first = 1'b1; end
            OP_N1B: begin s_mx = e_ab[0]; s_my = e_ac[2]; s_neg = 1'b1; end
            OP_N2A: begin s_mx = e_ab[0]; s_my = e_ac[1]; s_first = 1'b1; end
            OP_N2B: begin s_mx = e_ab[1]; s_my = e_ac[0]; s_neg = 1'b1; end
            OP_D0:  begin s_mx = e_n[0];  s_my = e_pa[0]; s_first = 1'b1; end
            OP_D1:  begin s_mx = e_n[1];  s_my = e_pa[1]; end
            OP_D2:  begin s_mx = e_n[2];  s_my = e_pa[2]; end
            OP_Q0: begin
                s_mx = e_n[0]; s_my = e_n[0]; s_first = 1'b1; s_len = CW'(NW);
            end
            OP_Q1:  begin s_mx = e_n[1]; s_my = e_n[1]; s_len = CW'(NW); end
            OP_Q2:  begin s_mx = e_n[2]; s_my = e_n[2]; s_len = CW'(NW); end
            OP_DD: begin
                s_mx = e_dot; s_my = e_dot; s_first = 1'b1; s_len = CW'(TW);
            end
            default: begin s_mx = e_ab[1]; s_my = e_ac[2]; end
        endcase
    end

    assign s_magx   = s_mx[TW-1] ? TW'(-s_mx) : TW'(s_mx);
    assign s_magy   = s_my[TW-1] ? TW'(-s_my) : TW'(s_my);
    assign s_padd   = r_pneg ? -$signed({1'b0, r_prod}) : $signed({1'b0, r_prod});
    assign s_accn   = (s_first ? AW'(0) : r_acc) + s_padd;
    assign s_accneg = -s_accn;
    assign s_deg    = (r_nn == '0);
    assign s_rdiff  = r_r - r_t;
    assign s_fit    = (r_t <= r_r);
    assign s_dist   = s_deg ? '0 : r_q;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) begin
                n_state = ST_LOAD;
            end
            ST_LOAD: n_state = ST_MUL;
            ST_MUL:  if (r_cnt == r_len - 1'b1) begin
                n_state = ST_ACC;
            end
            ST_ACC: begin
                if (r_op == OP_DD) begin
                    n_state = s_deg ? ST_FIN : ST_SQ_T;
                end else begin
                    n_state = ST_LOAD;
                end
            end
            ST_SQ_T: n_state = ST_SQ_C;
            ST_SQ_C: if (r_k == '0) begin
                n_state = ST_FIN;
            end else begin
                n_state = ST_SQ_T;
            end
            ST_FIN: if (s_ctrl.load_out) begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ctrl.in_stall = (r_state != ST_IDLE);
        s_ctrl.load_out = (r_state == ST_FIN) && (!r_ovalid || !i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_op     <= OP_N0A;
            r_ovalid <= 1'b0;
            r_min    <= '1;
            r_max    <= '0;
        end else begin
            r_state <= n_state;
            if (s_ctrl.load_out) begin
                r_ovalid <= 1'b1;
                if (!s_deg && s_dist < r_min) r_min <= s_dist;
                if (!s_deg && s_dist > r_max) r_max <= s_dist;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            if (r_state == ST_IDLE) begin
                r_op <= OP_N0A;
            end else if (r_state == ST_ACC && r_op != OP_DD) begin
                r_op <= t_op'(r_op + 4'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) begin
            for (int i = 0; i < 3; i++) begin
                r_ab[i] <= s_bin[i] - s_ain[i];
                r_ac[i] <= s_cin[i] - s_ain[i];
                r_pa[i] <= s_pin[i] - s_ain[i];
            end
        end
        if (r_state == ST_LOAD) begin
            r_mcand  <= {{(PW - TW){1'b0}}, s_magx};
            r_mplier <= s_magy;
            r_pneg   <= s_mx[TW-1] ^ s_my[TW-1] ^ s_neg;
            r_prod   <= '0;
            r_cnt    <= '0;
            r_len    <= s_len;
        end
        if (r_state == ST_MUL) begin
            if (r_mplier[0]) r_prod <= r_prod + r_mcand;
            r_mcand  <= {r_mcand[PW-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[TW-1:1]};
            r_cnt    <= r_cnt + 1'b1;
        end
        if (r_state == ST_ACC) begin
            r_acc <= s_accn;
            case (r_op)
                OP_N0B: r_n[0] <= s_accn[NW-1:0];
                OP_N1B: r_n[1] <= s_accn[NW-1:0];
                OP_N2B: r_n[2] <= s_accn[NW-1:0];
                OP_D2:  r_dot  <= s_accn[AW-1] ? s_accneg[TW-1:0] : s_accn[TW-1:0];
                OP_Q2:  r_nn   <= s_accn[NNW-1:0];
                OP_DD: begin
                    r_r <= {{(SW - PW){1'b0}}, s_accn[PW-1:0]};
                    r_a <= '0;
                    r_b <= {{(SW - NNW - QSH){1'b0}}, r_nn, {QSH{1'b0}}};
                    r_q <= '0;
                    r_k <= KW'(DIST_W - 1);
                end
                default: ;
            endcase
        end
        // remainder R = dd - q^2*nn, A = 2^(k+1)*q*nn, B = 4^k*nn
        if (r_state == ST_SQ_T) begin
            r_t <= r_a + r_b;
        end
        if (r_state == ST_SQ_C) begin
            if (s_fit) begin
                r_r      <= s_rdiff;
                r_a      <= (r_a + {r_b[SW-2:0], 1'b0}) >> 1;
                r_q[r_k] <= 1'b1;
            end else begin
                r_a <= r_a >> 1;
            end
            r_b <= r_b >> 2;
            r_k <= r_k - 1'b1;
        end
        if (s_ctrl.load_out) begin
            r_dist <= s_dist;
            r_odeg <= s_deg;
        end
    end

    assign o_in_stall   = s_ctrl.in_stall;
    assign o_out_valid  = r_ovalid;
    assign o_distance   = r_dist;
    assign o_range_min  = r_min;
    assign o_range_max  = r_max;
    assign o_degenerate = r_odeg;

`ifndef SYNTHESIS
    a_range_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_degenerate |-> o_range_min <= o_distance && o_distance <= o_range_max)
        else $error("distance outside tracked range");
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_degenerate |-> o_distance == '0)
        else $error("degenerate result with nonzero distance");
    a_mul_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_MUL |-> r_cnt < r_len)
        else $error("multiplier ran past its operand");
    a_fin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_ctrl.load_out |=> r_state == ST_IDLE && o_out_valid)
        else $error("result load did not complete transaction");
`endif

endmodule
